[hw/rtl/port_probe_result_tracker_defines.svh]
// Assertion macros shared by the port probe tracker checkers.
// Needs nothing else; include it by bare file name.
`ifndef PORT_PROBE_RESULT_TRACKER_DEFINES_SVH
`define PORT_PROBE_RESULT_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port probe tracker check failed");

// Next-cycle implication, disabled while reset is high.
`define PPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port probe tracker check failed");

`endif

[hw/rtl/ppr_pkg.sv]
// Shared types and constants of the port probe result tracker.
// No dependencies; every other RTL module imports it.
package ppr_pkg;

  localparam int NUM_PORTS = 65536;
  localparam int PORT_AW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  localparam logic [16:0] OPEN_CAP_RESET = 17'h10000;

  // Incoming outcome codes.
  localparam logic [2:0] RC_OPEN      = 3'd0;
  localparam logic [2:0] RC_REFUSED   = 3'd1;
  localparam logic [2:0] RC_TIMEOUT   = 3'd2;
  localparam logic [2:0] RC_UNREACH   = 3'd3;
  localparam logic [2:0] RC_RESET     = 3'd4;
  localparam logic [2:0] RC_CANCELLED = 3'd5;

  // Per-port state codes.
  typedef enum logic [2:0] {
    ST_UNKNOWN   = 3'd0,
    ST_OPEN      = 3'd1,
    ST_CLOSED    = 3'd2,
    ST_FILTERED  = 3'd3,
    ST_UNREACH   = 3'd4,
    ST_RESET     = 3'd5,
    ST_LOCALERR  = 3'd6,
    ST_CANCELLED = 3'd7
  } port_state_t;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    K_OPEN     = 3'd0,
    K_REFUSED  = 3'd1,
    K_TIMEOUT  = 3'd2,
    K_UNREACH  = 3'd3,
    K_RESET    = 3'd4,
    K_CANCEL   = 3'd5,
    K_LOCALERR = 3'd6
  } op_kind_t;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] rtt;
    op_kind_t    kind;
    logic        in_range;
  } op_t;

  // Back-to-front control.
  typedef struct packed {
    logic pop;
    logic clearing;
  } fq_ctl_t;

  typedef struct packed {
    logic [15:0] port_out;
    logic [31:0] rtt_out;
    logic [2:0]  new_state;
    logic        record_open;
    logic [31:0] scanned_total;
    logic [31:0] cancelled_total;
    logic [16:0] filtered_now;
    logic [31:0] refused_total;
    logic [31:0] unreachable_total;
    logic [31:0] reset_total;
    logic [31:0] local_error_total;
    logic [16:0] open_records;
  } res_t;

endpackage

[hw/rtl/ppr_front.sv]
// Front end: accepts probe outcomes, classifies them and queues them.
// Depends on ppr_pkg.
module ppr_front import ppr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] port,
  input  logic [2:0]  result_code,
  input  logic [31:0] rtt_us,
  input  fq_ctl_t     ctl,
  output logic        fq_valid,
  output op_t         fq_op
);

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  op_t        op_in;

  always_comb begin
    op_in.port     = port;
    op_in.rtt      = rtt_us;
    op_in.in_range = ({1'b0, port} < 17'(NUM_PORTS));
    unique case (result_code)
      RC_OPEN:      op_in.kind = K_OPEN;
      RC_REFUSED:   op_in.kind = K_REFUSED;
      RC_TIMEOUT:   op_in.kind = K_TIMEOUT;
      RC_UNREACH:   op_in.kind = K_UNREACH;
      RC_RESET:     op_in.kind = K_RESET;
      RC_CANCELLED: op_in.kind = K_CANCEL;
      default:      op_in.kind = K_LOCALERR;
    endcase
  end

  assign full     = ctl.clearing || (count == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = ctl.pop && (count != 2'd0);
  assign fq_valid = (count != 2'd0);
  assign fq_op    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[hw/rtl/ppr_out_queue.sv]
// Two-entry result queue between the back end and the result ports.
// Depends on ppr_pkg.
module ppr_out_queue import ppr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  res_t wr_data,
  output logic q_full,
  input  logic pop,
  output logic empty,
  output res_t head
);

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_full  = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = wr_en && !q_full;
  assign do_pop  = pop && !empty;
  assign head    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[hw/rtl/ppr_back.sv]
// Back end: per-port state table, event counters and transition rules.
// Depends on ppr_pkg.
module ppr_back import ppr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fq_valid,
  input  op_t         fq_op,
  output fq_ctl_t     ctl,
  input  logic        oq_full,
  output logic        oq_push,
  output res_t        oq_data,
  input  logic        cfg_valid,
  input  logic [16:0] cfg_data
);

  typedef enum logic [2:0] {
    BK_CLEAR = 3'b001,
    BK_IDLE  = 3'b010,
    BK_EXEC  = 3'b100
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  port_state_t tbl [NUM_PORTS];
  port_state_t rd_data;
  logic               mem_we;
  logic [PORT_AW-1:0] mem_waddr;
  port_state_t        mem_wdata;
  logic [PORT_AW-1:0] clr_addr;
  logic               clr_last;

  op_t         cur_op;
  logic [16:0] open_capacity;

  logic [31:0] scanned_count, scanned_count_next;
  logic [31:0] cancelled_count, cancelled_count_next;
  logic [16:0] filtered_count, filtered_count_next;
  logic [31:0] refused_count, refused_count_next;
  logic [31:0] unreachable_count, unreachable_count_next;
  logic [31:0] reset_state_count, reset_state_count_next;
  logic [31:0] local_error_count, local_error_count_next;
  logic [16:0] open_count, open_count_next;

  port_state_t prev;
  port_state_t nxt;
  logic        rec;
  logic        leave_dec;
  logic        exec;

  assign clr_last     = (clr_addr == PORT_AW'(NUM_PORTS - 1));
  assign ctl.clearing = (state == BK_CLEAR);
  assign ctl.pop      = (state == BK_IDLE) && fq_valid && !oq_full;
  assign exec         = (state == BK_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (clr_last) state_next = BK_IDLE;
      BK_IDLE:  if (ctl.pop) state_next = BK_EXEC;
      BK_EXEC:  state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_CLEAR;
      clr_addr      <= '0;
      open_capacity <= OPEN_CAP_RESET;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + PORT_AW'(1);
      end
      if (cfg_valid) begin
        open_capacity <= cfg_data;
      end
    end
  end

  // State table: one write and one registered read per cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = ST_UNKNOWN;
    if (state == BK_CLEAR) begin
      mem_we = 1'b1;
    end else if (exec) begin
      mem_we    = cur_op.in_range;
      mem_waddr = cur_op.port[PORT_AW-1:0];
      mem_wdata = nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl[mem_waddr] <= mem_wdata;
    end
    if (ctl.pop) begin
      rd_data <= tbl[fq_op.port[PORT_AW-1:0]];
      cur_op  <= fq_op;
    end
  end

  // Transition rules.
  always_comb begin
    prev                   = cur_op.in_range ? rd_data : ST_UNKNOWN;
    nxt                    = prev;
    rec                    = 1'b0;
    leave_dec              = (prev == ST_FILTERED) && (filtered_count != 17'd0);
    scanned_count_next     = scanned_count;
    cancelled_count_next   = cancelled_count;
    filtered_count_next    = filtered_count;
    refused_count_next     = refused_count;
    unreachable_count_next = unreachable_count;
    reset_state_count_next = reset_state_count;
    local_error_count_next = local_error_count;
    open_count_next        = open_count;
    if (cur_op.in_range) begin
      if (cur_op.kind == K_CANCEL) begin
        cancelled_count_next = cancelled_count + 32'd1;
        if (prev == ST_UNKNOWN) begin
          nxt = ST_CANCELLED;
        end
      end else begin
        scanned_count_next = scanned_count + 32'd1;
        unique case (cur_op.kind)
          K_OPEN: begin
            if (prev != ST_OPEN) begin
              nxt = ST_OPEN;
              if (open_count < open_capacity) begin
                open_count_next = open_count + 17'd1;
                rec             = 1'b1;
              end
              if (leave_dec) filtered_count_next = filtered_count - 17'd1;
            end
          end
          K_REFUSED: begin
            if (prev != ST_CLOSED) begin
              nxt                = ST_CLOSED;
              refused_count_next = refused_count + 32'd1;
              if (leave_dec) filtered_count_next = filtered_count - 17'd1;
            end
          end
          K_TIMEOUT: begin
            if (prev == ST_UNKNOWN) begin
              nxt                 = ST_FILTERED;
              filtered_count_next = filtered_count + 17'd1;
            end
          end
          default: begin
            if (prev == ST_UNKNOWN || prev == ST_FILTERED) begin
              if (leave_dec) filtered_count_next = filtered_count - 17'd1;
              if (cur_op.kind == K_UNREACH) begin
                nxt                    = ST_UNREACH;
                unreachable_count_next = unreachable_count + 32'd1;
              end else if (cur_op.kind == K_RESET) begin
                nxt                    = ST_RESET;
                reset_state_count_next = reset_state_count + 32'd1;
              end else begin
                nxt                    = ST_LOCALERR;
                local_error_count_next = local_error_count + 32'd1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanned_count     <= '0;
      cancelled_count   <= '0;
      filtered_count    <= '0;
      refused_count     <= '0;
      unreachable_count <= '0;
      reset_state_count <= '0;
      local_error_count <= '0;
      open_count        <= '0;
    end else if (exec) begin
      scanned_count     <= scanned_count_next;
      cancelled_count   <= cancelled_count_next;
      filtered_count    <= filtered_count_next;
      refused_count     <= refused_count_next;
      unreachable_count <= unreachable_count_next;
      reset_state_count <= reset_state_count_next;
      local_error_count <= local_error_count_next;
      open_count        <= open_count_next;
    end
  end

  assign oq_push = exec;

  always_comb begin
    oq_data.port_out          = cur_op.port;
    oq_data.rtt_out           = rec ? cur_op.rtt : 32'd0;
    oq_data.new_state         = nxt;
    oq_data.record_open       = rec;
    oq_data.scanned_total     = scanned_count_next;
    oq_data.cancelled_total   = cancelled_count_next;
    oq_data.filtered_now      = filtered_count_next;
    oq_data.refused_total     = refused_count_next;
    oq_data.unreachable_total = unreachable_count_next;
    oq_data.reset_total       = reset_state_count_next;
    oq_data.local_error_total = local_error_count_next;
    oq_data.open_records      = open_count_next;
  end

endmodule

[hw/rtl/port_probe_result_tracker.sv]
// Top level of the port probe result tracker.
// Depends on ppr_pkg, ppr_front, ppr_back and ppr_out_queue.
//
// Usage: each beat pushed on the input queue (push/full) is one probe outcome
// for a port: the port number, the outcome code and the round-trip time.
// Every input beat yields exactly one result beat on the output queue
// (empty/pop), carrying the port's new state, the open-record flag, the
// round-trip time when a record is emitted, and a snapshot of all counters
// taken after the update.
// The open_capacity register is written through its own valid/ready channel;
// ready is always high and writes should only happen while the block is idle.
// Timing: an outcome waits in a two-entry front queue, then the back end
// reads the port's state table entry in its idle state and applies the
// rules and writes it back in its exec state, so it takes a new outcome only
// once the last one is written back, a limit set by the table
// read-modify-write. An outcome passes front queue, table read, result queue.
// After reset the state table is swept back to unknown, one entry per cycle;
// full stays high during the sweep.
// When the receiver stops popping, the two-entry result queue fills, the
// back end holds, then the front queue fills and full rises; nothing is lost.
module port_probe_result_tracker import ppr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] port,
  input  logic [2:0]  result_code,
  input  logic [31:0] rtt_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] open_capacity,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] port_out,
  output logic [31:0] rtt_out,
  output logic [2:0]  new_state,
  output logic        record_open,
  output logic [31:0] scanned_total,
  output logic [31:0] cancelled_total,
  output logic [16:0] filtered_now,
  output logic [31:0] refused_total,
  output logic [31:0] unreachable_total,
  output logic [31:0] reset_total,
  output logic [31:0] local_error_total,
  output logic [16:0] open_records
);

  fq_ctl_t ctl;
  logic    fq_valid;
  op_t     fq_op;
  logic    oq_full;
  logic    oq_push;
  res_t    oq_data;
  res_t    head;

  // The capacity register lives in the back end and takes a write any cycle.
  assign cfg_ready = 1'b1;

  ppr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .port        (port),
    .result_code (result_code),
    .rtt_us      (rtt_us),
    .ctl         (ctl),
    .fq_valid    (fq_valid),
    .fq_op       (fq_op)
  );

  ppr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fq_valid  (fq_valid),
    .fq_op     (fq_op),
    .ctl       (ctl),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_data   (oq_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (open_capacity)
  );

  ppr_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_push),
    .wr_data (oq_data),
    .q_full  (oq_full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign port_out          = head.port_out;
  assign rtt_out           = head.rtt_out;
  assign new_state         = head.new_state;
  assign record_open       = head.record_open;
  assign scanned_total     = head.scanned_total;
  assign cancelled_total   = head.cancelled_total;
  assign filtered_now      = head.filtered_now;
  assign refused_total     = head.refused_total;
  assign unreachable_total = head.unreachable_total;
  assign reset_total       = head.reset_total;
  assign local_error_total = head.local_error_total;
  assign open_records      = head.open_records;

endmodule

[hw/rtl/ppr_checker.sv]
// Port-level checks for the port probe result tracker, bound to the top level.
// Depends on ppr_pkg and port_probe_result_tracker_defines.svh.
`include "port_probe_result_tracker_defines.svh"

module ppr_checker import ppr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] rtt_out,
  input logic [2:0]  new_state,
  input logic        record_open,
  input logic [31:0] scanned_total
);

  // The table sweep after reset keeps the input side closed.
  `PPR_ASSERT_IMPL(a_sweep_after_reset, clk, rst, $fell(rst), full)

  // A record is only emitted for a port that is now open.
  `PPR_ASSERT_IMPL(a_record_is_open, clk, rst, !empty && record_open, new_state == ST_OPEN)

  // Without a record the round-trip time reads as zero.
  `PPR_ASSERT_IMPL(a_rtt_zero, clk, rst, !empty && !record_open, rtt_out == 32'd0)

  // A waiting result holds until it is popped.
  `PPR_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(scanned_total))

endmodule

bind port_probe_result_tracker ppr_checker u_checker (.*);

[test/port_probe_result_tracker_tb.sv]
// Testbench for the port probe result tracker: directed table plus random outcomes,
// every result beat checked against a behavioral copy of the per-port state rules.
// Depends on ppr_pkg and port_probe_result_tracker.
`timescale 1ns / 1ps

module port_probe_result_tracker_tb;
  import ppr_pkg::*;

  // The state table sweep after reset accepts nothing, so the watchdog
  // has to sit well above the length of the sweep.
  localparam int WATCHDOG_LIMIT  = 300000;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int NUM_PHASES      = 5;
  localparam int SQUEEZE_CYCLES  = 400;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MAX_REPORTS     = 10;
  localparam int POOL_SPAN       = 48;
  localparam int POOL_MOVE       = 60;

  // Outcome codes that the package leaves unnamed; both map to local error.
  localparam logic [2:0] RC_OTHER     = 3'd6;
  localparam logic [2:0] RC_OTHER_ALT = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] port = '0;
  logic [2:0]  result_code = '0;
  logic [31:0] rtt_us = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] open_capacity = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] port_out;
  logic [31:0] rtt_out;
  logic [2:0]  new_state;
  logic        record_open;
  logic [31:0] scanned_total;
  logic [31:0] cancelled_total;
  logic [16:0] filtered_now;
  logic [31:0] refused_total;
  logic [31:0] unreachable_total;
  logic [31:0] reset_total;
  logic [31:0] local_error_total;
  logic [16:0] open_records;

  port_probe_result_tracker uut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .port              (port),
    .result_code       (result_code),
    .rtt_us            (rtt_us),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .open_capacity     (open_capacity),
    .empty             (empty),
    .pop               (pop),
    .port_out          (port_out),
    .rtt_out           (rtt_out),
    .new_state         (new_state),
    .record_open       (record_open),
    .scanned_total     (scanned_total),
    .cancelled_total   (cancelled_total),
    .filtered_now      (filtered_now),
    .refused_total     (refused_total),
    .unreachable_total (unreachable_total),
    .reset_total       (reset_total),
    .local_error_total (local_error_total),
    .open_records      (open_records)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One row of the directed table. Where typed is set, the new state and the
  // record flag of that beat are written out here by hand and replace what
  // the tracker copy below works out; the counters always come from the copy.
  typedef struct packed {
    logic [15:0] port;
    logic [2:0]  code;
    logic [31:0] rtt;
    logic        typed;
    port_state_t st;
    logic        rec;
  } probe_row_t;

  // The directed part runs with a capacity of two open records, so the third
  // port to open hits the capacity limit.
  localparam logic [16:0] DIRECTED_CAPACITY = 17'd2;
  localparam int DIRECTED_ROWS = 26;

  probe_row_t dir_rows [DIRECTED_ROWS] = '{
    // First open on port 0 with the largest round-trip time; a record comes out.
    '{16'd0,     RC_OPEN,      32'hFFFF_FFFF, 1'b1, ST_OPEN,      1'b1},
    // Open again on an open port: no second record.
    '{16'd0,     RC_OPEN,      32'd5,         1'b1, ST_OPEN,      1'b0},
    '{16'd65535, RC_REFUSED,   32'd0,         1'b1, ST_CLOSED,    1'b0},
    '{16'd65535, RC_REFUSED,   32'd9,         1'b1, ST_CLOSED,    1'b0},
    // Open overrides closed; this is the second and last record allowed.
    '{16'd65535, RC_OPEN,      32'h1234_5678, 1'b1, ST_OPEN,      1'b1},
    '{16'd1,     RC_TIMEOUT,   32'd0,         1'b1, ST_FILTERED,  1'b0},
    '{16'd1,     RC_TIMEOUT,   32'd3,         1'b1, ST_FILTERED,  1'b0},
    // Capacity is reached: the port still opens, but no record and no time.
    '{16'd1,     RC_OPEN,      32'd77,        1'b1, ST_OPEN,      1'b0},
    // Refused overrides open.
    '{16'd0,     RC_REFUSED,   32'd1,         1'b1, ST_CLOSED,    1'b0},
    '{16'd2,     RC_TIMEOUT,   32'd0,         1'b1, ST_FILTERED,  1'b0},
    '{16'd2,     RC_UNREACH,   32'd0,         1'b1, ST_UNREACH,   1'b0},
    '{16'd2,     RC_TIMEOUT,   32'd0,         1'b1, ST_UNREACH,   1'b0},
    '{16'd3,     RC_RESET,     32'd0,         1'b1, ST_RESET,     1'b0},
    '{16'd4,     RC_OTHER,     32'd0,         1'b1, ST_LOCALERR,  1'b0},
    // Code seven is treated as another local error.
    '{16'd5,     RC_OTHER_ALT, 32'd0,         1'b1, ST_LOCALERR,  1'b0},
    '{16'd6,     RC_CANCELLED, 32'd0,         1'b1, ST_CANCELLED, 1'b0},
    '{16'd6,     RC_TIMEOUT,   32'd0,         1'b0, ST_UNKNOWN,   1'b0},
    '{16'd6,     RC_REFUSED,   32'd0,         1'b1, ST_CLOSED,    1'b0},
    '{16'd3,     RC_CANCELLED, 32'd0,         1'b0, ST_UNKNOWN,   1'b0},
    '{16'd7,     RC_TIMEOUT,   32'd0,         1'b1, ST_FILTERED,  1'b0},
    '{16'd7,     RC_REFUSED,   32'd0,         1'b1, ST_CLOSED,    1'b0},
    '{16'd8,     RC_TIMEOUT,   32'd0,         1'b1, ST_FILTERED,  1'b0},
    '{16'd8,     RC_OTHER_ALT, 32'd0,         1'b1, ST_LOCALERR,  1'b0},
    '{16'd9,     RC_TIMEOUT,   32'd0,         1'b1, ST_FILTERED,  1'b0},
    '{16'd9,     RC_RESET,     32'd0,         1'b1, ST_RESET,     1'b0},
    '{16'd4,     RC_UNREACH,   32'd0,         1'b0, ST_UNKNOWN,   1'b0}
  };

  // Behavioral copy of the tracker: the per-port table, the counters and the
  // capacity register as the block should hold them.
  port_state_t port_tab [NUM_PORTS];
  logic [31:0] n_scanned   = '0;
  logic [31:0] n_cancelled = '0;
  logic [31:0] n_refused   = '0;
  logic [31:0] n_unreach   = '0;
  logic [31:0] n_reset     = '0;
  logic [31:0] n_localerr  = '0;
  logic [16:0] n_filtered  = '0;
  logic [16:0] n_open      = '0;
  logic [16:0] cap_model   = OPEN_CAP_RESET;

  // Result beats the block still owes, oldest first.
  res_t owed_results [$];

  int mismatches  = 0;
  int idle_cycles = 0;

  // Row currently offered by the sender, read by the monitor when it is taken.
  logic        cur_typed = 1'b0;
  port_state_t cur_state = ST_UNKNOWN;
  logic        cur_rec = 1'b0;

  // Sender pacing and the receiver's long hold-off request.
  int burst_left = 0;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;

  function automatic void leave_filtered(input port_state_t prev);
    if (prev == ST_FILTERED && n_filtered != 0)
      n_filtered = n_filtered - 17'd1;
  endfunction

  // Applies one probe outcome to the copy and returns the result beat it
  // should produce.
  function automatic res_t track_outcome(input logic [15:0] p, input logic [2:0] c,
                                         input logic [31:0] r);
    res_t        o;
    port_state_t prev;
    port_state_t nxt;
    logic        rec;
    prev = ST_UNKNOWN;
    nxt  = ST_UNKNOWN;
    rec  = 1'b0;
    if (p < NUM_PORTS) begin
      prev = port_tab[p];
      nxt  = prev;
      if (c == RC_CANCELLED) begin
        // A cancel only marks a port nothing is known about yet.
        if (prev == ST_UNKNOWN)
          nxt = ST_CANCELLED;
        n_cancelled = n_cancelled + 32'd1;
      end else begin
        n_scanned = n_scanned + 32'd1;
        case (c)
          RC_OPEN: begin
            if (prev != ST_OPEN) begin
              nxt = ST_OPEN;
              if (n_open < cap_model) begin
                n_open = n_open + 17'd1;
                rec = 1'b1;
              end
              leave_filtered(prev);
            end
          end
          RC_REFUSED: begin
            if (prev != ST_CLOSED) begin
              leave_filtered(prev);
              nxt = ST_CLOSED;
              n_refused = n_refused + 32'd1;
            end
          end
          RC_TIMEOUT: begin
            if (prev == ST_UNKNOWN) begin
              nxt = ST_FILTERED;
              n_filtered = n_filtered + 17'd1;
            end
          end
          default: begin
            // Unreachable, reset and local errors only land on ports that are
            // unknown or merely filtered.
            if (prev == ST_UNKNOWN || prev == ST_FILTERED) begin
              leave_filtered(prev);
              case (c)
                RC_UNREACH: begin
                  nxt = ST_UNREACH;
                  n_unreach = n_unreach + 32'd1;
                end
                RC_RESET: begin
                  nxt = ST_RESET;
                  n_reset = n_reset + 32'd1;
                end
                default: begin
                  nxt = ST_LOCALERR;
                  n_localerr = n_localerr + 32'd1;
                end
              endcase
            end
          end
        endcase
      end
      port_tab[p] = nxt;
    end
    o.port_out          = p;
    o.rtt_out           = rec ? r : 32'd0;
    o.new_state         = nxt;
    o.record_open       = rec;
    o.scanned_total     = n_scanned;
    o.cancelled_total   = n_cancelled;
    o.filtered_now      = n_filtered;
    o.refused_total     = n_refused;
    o.unreachable_total = n_unreach;
    o.reset_total       = n_reset;
    o.local_error_total = n_localerr;
    o.open_records      = n_open;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Monitor. Both handshakes are sampled at the rising edge; the inputs have
  // been stable since the falling edge before it. The result side is checked
  // first, which can never hide a beat since a result never leaves in the
  // cycle its input beat is taken.
  always @(posedge clk) begin : beat_monitor
    res_t want;
    bit   moved;
    moved = 1'b0;
    if (!rst && pop && !empty) begin
      moved = 1'b1;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat for port %h with nothing expected", $realtime, port_out);
      end else begin
        want = owed_results.pop_front();
        check_field("port_out",          want.port_out,          port_out);
        check_field("rtt_out",           want.rtt_out,           rtt_out);
        check_field("new_state",         want.new_state,         new_state);
        check_field("record_open",       want.record_open,       record_open);
        check_field("scanned_total",     want.scanned_total,     scanned_total);
        check_field("cancelled_total",   want.cancelled_total,   cancelled_total);
        check_field("filtered_now",      want.filtered_now,      filtered_now);
        check_field("refused_total",     want.refused_total,     refused_total);
        check_field("unreachable_total", want.unreachable_total, unreachable_total);
        check_field("reset_total",       want.reset_total,       reset_total);
        check_field("local_error_total", want.local_error_total, local_error_total);
        check_field("open_records",      want.open_records,      open_records);
      end
    end
    if (!rst && push && !full) begin
      moved = 1'b1;
      want = track_outcome(port, result_code, rtt_us);
      if (cur_typed) begin
        want.new_state   = cur_state;
        want.record_open = cur_rec;
        want.rtt_out     = cur_rec ? rtt_us : 32'd0;
      end
      owed_results.push_back(want);
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Watchdog: too long without any beat moving on either side ends the run.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver. It pops on a 16-bit stall mask that is redrawn at random
  // intervals; about a quarter of the masks never stall. Once, on request,
  // it stops popping altogether for a long stretch so that the result queue
  // and then the input queue fill up and full rises.
  initial begin : receiver
    int          hold_left;
    int          pat_left;
    int          pat_idx;
    logic [15:0] stall_mask;
    hold_left  = 0;
    pat_left   = 0;
    pat_idx    = 0;
    stall_mask = '0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left = SQUEEZE_CYCLES;
        pop <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom & $urandom);
          pat_left = $urandom_range(16, 96);
        end
        pat_left--;
        pop <= !stall_mask[pat_idx % 16];
        pat_idx++;
      end
    end
  end

  // Offers one beat from a falling edge and holds it until the edge that
  // takes it; returns on the falling edge after that with push still high.
  task automatic offer_beat(input logic [15:0] p, input logic [2:0] c, input logic [31:0] r,
                            input logic typed, input port_state_t st, input logic rec);
    cur_typed = typed;
    cur_state = st;
    cur_rec   = rec;
    push        <= 1'b1;
    port        <= p;
    result_code <= c;
    rtt_us      <= r;
    do
      @(posedge clk);
    while (full);
    @(negedge clk);
  endtask

  // Bursts of back-to-back beats separated by random gaps; push is only
  // lowered when a gap is actually taken.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Waits until every owed result has come back, then lets the block drain so
  // nothing is still in flight.
  task automatic settle();
    push <= 1'b0;
    while (owed_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the capacity register; called on a falling edge while no beat is in flight.
  task automatic write_capacity(input logic [16:0] value);
    cfg_valid     <= 1'b1;
    open_capacity <= value;
    do
      @(posedge clk);
    while (!cfg_ready);
    cap_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence: reset, the directed table, then random phases that each
  // run under a different capacity, with the extremes among them.
  initial begin : stimulus
    logic [15:0] pool_base;
    logic [15:0] last_port;
    logic [15:0] p;
    logic [2:0]  c;
    logic [31:0] r;
    logic [16:0] cap;
    int          pick;
    for (int i = 0; i < NUM_PORTS; i++)
      port_tab[i] = ST_UNKNOWN;
    pool_base = '0;
    last_port = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The register may be written during the clearing sweep; full holds the
    // first beat off until the sweep is done.
    write_capacity(DIRECTED_CAPACITY);
    foreach (dir_rows[i]) begin
      offer_beat(dir_rows[i].port, dir_rows[i].code, dir_rows[i].rtt,
                 dir_rows[i].typed, dir_rows[i].st, dir_rows[i].rec);
      pace_sender();
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: cap = OPEN_CAP_RESET;
        1: cap = 17'd0;
        2: cap = n_open + 17'd3;          // runs into the limit within the phase
        3: cap = 17'h0FFFF;
        default: cap = 17'($urandom_range(0, 65536));
      endcase
      write_capacity(cap);
      if (phase == 1)
        squeeze_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Beats mostly land on a small moving pool of ports so each port goes
        // through several outcomes; a share repeats the previous port back to
        // back, and a few pick any port at all.
        if (n % POOL_MOVE == 0)
          pool_base = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
          p = 16'($urandom);
        else if (pick < 35)
          p = last_port;
        else
          p = pool_base + 16'($urandom_range(0, POOL_SPAN - 1));
        last_port = p;
        c = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 15))
          0: r = 32'd0;
          1: r = 32'hFFFF_FFFF;
          default: r = $urandom;
        endcase
        offer_beat(p, c, r, 1'b0, ST_UNKNOWN, 1'b0);
        pace_sender();
      end
    end

    settle();
    if (mismatches == 0 && owed_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_front.sv
hw/rtl/ppr_out_queue.sv
hw/rtl/ppr_back.sv
hw/rtl/port_probe_result_tracker.sv
hw/rtl/ppr_checker.sv
test/port_probe_result_tracker_tb.sv
